>>> rtl/core/orot_pkg.sv
package orot_pkg;

  // Field formats
  localparam int COORD_W   = 24;             // centre / extent width
  localparam int AXIS_W    = 16;             // axis component width
  localparam int AXIS_FRAC = AXIS_W - 2;     // axis fraction bits

  // Port field widths, fixed by the channel definition
  localparam int CENTER_W  = 48;
  localparam int AXES_W    = 64;
  localparam int EXT_W     = 48;

  // Internal arithmetic widths
  localparam int DIFF_W    = COORD_W + 1;          // centre difference
  localparam int PRODA_W   = AXIS_W + DIFF_W;      // axis * difference
  localparam int PROJ_W    = PRODA_W + 1;          // dot product / its magnitude
  localparam int PRODX_W   = 2 * AXIS_W;           // axis * axis
  localparam int CROSS_W   = PRODX_W + 1;          // signed axis dot product
  localparam int XMAG_W    = 2 * AXIS_W;           // |axis . axis| <= 2^(2*AXIS_W-1)
  localparam int TERM_W    = COORD_W + XMAG_W;     // extent * |axis . axis|
  localparam int CMP_W     = TERM_W + 2;           // three-term extent sum

  localparam int NUM_AXES  = 4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Decoded pair of rectangles
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [AXIS_W-1:0] a0;
    logic signed [AXIS_W-1:0] a1;
    logic signed [AXIS_W-1:0] a2;
    logic signed [AXIS_W-1:0] a3;
    logic signed [AXIS_W-1:0] b0;
    logic signed [AXIS_W-1:0] b1;
    logic signed [AXIS_W-1:0] b2;
    logic signed [AXIS_W-1:0] b3;
    logic [COORD_W-1:0]       ea0;
    logic [COORD_W-1:0]       ea1;
    logic [COORD_W-1:0]       eb0;
    logic [COORD_W-1:0]       eb1;
  } orot_item_t;

endpackage

>>> rtl/core/orot_if.sv
interface orot_in_if
  import orot_pkg::*;
;

  logic                valid;
  logic                ready;
  logic [CENTER_W-1:0] first_center;
  logic [AXES_W-1:0]   first_axes;
  logic [EXT_W-1:0]    first_extents;
  logic [CENTER_W-1:0] second_center;
  logic [AXES_W-1:0]   second_axes;
  logic [EXT_W-1:0]    second_extents;

  modport source (
    output valid, first_center, first_axes, first_extents,
           second_center, second_axes, second_extents,
    input  ready
  );
  modport sink (
    input  valid, first_center, first_axes, first_extents,
           second_center, second_axes, second_extents,
    output ready
  );
endinterface

interface orot_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

>>> rtl/core/orot_front.sv
module orot_front
  import orot_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  orot_in_if.sink    in_bus,
  output logic       push_valid,
  input  logic       push_ready,
  output orot_item_t push_item
);

  logic       fr_valid_r;
  orot_item_t fr_item_r;
  orot_item_t dec_nxt;
  logic       fr_ready;

  logic [2*COORD_W-1:0] ca, cb, ea, eb;
  logic [4*AXIS_W-1:0]  aa, ab;
  logic signed [COORD_W-1:0] xa, ya, xb, yb;

  // unpack; missing high bits read as zero
  always_comb begin
    ca = (2*COORD_W)'(in_bus.first_center);
    cb = (2*COORD_W)'(in_bus.second_center);
    ea = (2*COORD_W)'(in_bus.first_extents);
    eb = (2*COORD_W)'(in_bus.second_extents);
    aa = (4*AXIS_W)'(in_bus.first_axes);
    ab = (4*AXIS_W)'(in_bus.second_axes);
    xa = signed'(ca[COORD_W-1:0]);
    ya = signed'(ca[2*COORD_W-1:COORD_W]);
    xb = signed'(cb[COORD_W-1:0]);
    yb = signed'(cb[2*COORD_W-1:COORD_W]);

    dec_nxt.dx  = DIFF_W'(xa) - DIFF_W'(xb);
    dec_nxt.dy  = DIFF_W'(ya) - DIFF_W'(yb);
    dec_nxt.a0  = signed'(aa[AXIS_W-1:0]);
    dec_nxt.a1  = signed'(aa[2*AXIS_W-1:AXIS_W]);
    dec_nxt.a2  = signed'(aa[3*AXIS_W-1:2*AXIS_W]);
    dec_nxt.a3  = signed'(aa[4*AXIS_W-1:3*AXIS_W]);
    dec_nxt.b0  = signed'(ab[AXIS_W-1:0]);
    dec_nxt.b1  = signed'(ab[2*AXIS_W-1:AXIS_W]);
    dec_nxt.b2  = signed'(ab[3*AXIS_W-1:2*AXIS_W]);
    dec_nxt.b3  = signed'(ab[4*AXIS_W-1:3*AXIS_W]);
    dec_nxt.ea0 = ea[COORD_W-1:0];
    dec_nxt.ea1 = ea[2*COORD_W-1:COORD_W];
    dec_nxt.eb0 = eb[COORD_W-1:0];
    dec_nxt.eb1 = eb[2*COORD_W-1:COORD_W];
  end

  assign fr_ready     = !fr_valid_r || push_ready;
  assign in_bus.ready = fr_ready;
  assign push_valid   = fr_valid_r;
  assign push_item    = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (fr_ready) begin
      fr_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_ready && in_bus.valid) begin
      fr_item_r <= dec_nxt;
    end
  end

endmodule

>>> rtl/core/orot_queue.sv
module orot_queue
  import orot_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  orot_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output orot_item_t pop_item
);

  orot_item_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/core/orot_back.sv
module orot_back
  import orot_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  orot_item_t pop_item,
  orot_out_if.source out_bus
);

  // stage valids and advance enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_bus.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign pop_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= pop_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // S1: products
  logic signed [PRODA_W-1:0] pa_r [8];
  logic signed [PRODX_W-1:0] px_r [8];
  logic [COORD_W-1:0]        ext1_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en1 && pop_valid) begin
      pa_r[0] <= PRODA_W'(pop_item.a0) * PRODA_W'(pop_item.dx);
      pa_r[1] <= PRODA_W'(pop_item.a1) * PRODA_W'(pop_item.dy);
      pa_r[2] <= PRODA_W'(pop_item.a2) * PRODA_W'(pop_item.dx);
      pa_r[3] <= PRODA_W'(pop_item.a3) * PRODA_W'(pop_item.dy);
      pa_r[4] <= PRODA_W'(pop_item.b0) * PRODA_W'(pop_item.dx);
      pa_r[5] <= PRODA_W'(pop_item.b1) * PRODA_W'(pop_item.dy);
      pa_r[6] <= PRODA_W'(pop_item.b2) * PRODA_W'(pop_item.dx);
      pa_r[7] <= PRODA_W'(pop_item.b3) * PRODA_W'(pop_item.dy);
      px_r[0] <= PRODX_W'(pop_item.a0) * PRODX_W'(pop_item.b0);
      px_r[1] <= PRODX_W'(pop_item.a1) * PRODX_W'(pop_item.b1);
      px_r[2] <= PRODX_W'(pop_item.a0) * PRODX_W'(pop_item.b2);
      px_r[3] <= PRODX_W'(pop_item.a1) * PRODX_W'(pop_item.b3);
      px_r[4] <= PRODX_W'(pop_item.a2) * PRODX_W'(pop_item.b0);
      px_r[5] <= PRODX_W'(pop_item.a3) * PRODX_W'(pop_item.b1);
      px_r[6] <= PRODX_W'(pop_item.a2) * PRODX_W'(pop_item.b2);
      px_r[7] <= PRODX_W'(pop_item.a3) * PRODX_W'(pop_item.b3);
      // own extent per axis: ea0, ea1, eb0, eb1
      ext1_r[0] <= pop_item.ea0;
      ext1_r[1] <= pop_item.ea1;
      ext1_r[2] <= pop_item.eb0;
      ext1_r[3] <= pop_item.eb1;
    end
  end

  // S2: dot products and magnitudes
  function automatic logic [PROJ_W-1:0] proj_mag(input logic signed [PRODA_W-1:0] p,
                                                 input logic signed [PRODA_W-1:0] q);
    logic signed [PROJ_W-1:0] s;
    s = PROJ_W'(p) + PROJ_W'(q);
    return s[PROJ_W-1] ? PROJ_W'(-s) : PROJ_W'(s);
  endfunction

  function automatic logic [XMAG_W-1:0] cross_mag(input logic signed [PRODX_W-1:0] p,
                                                  input logic signed [PRODX_W-1:0] q);
    logic signed [CROSS_W-1:0] s;
    logic signed [CROSS_W-1:0] m;
    s = CROSS_W'(p) + CROSS_W'(q);
    m = s[CROSS_W-1] ? -s : s;
    return m[XMAG_W-1:0];
  endfunction

  logic [PROJ_W-1:0]  proj_r [NUM_AXES];
  logic [XMAG_W-1:0]  xm_r   [NUM_AXES];   // |a0.b0|, |a0.b1|, |a1.b0|, |a1.b1|
  logic [COORD_W-1:0] ext2_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        proj_r[k] <= proj_mag(pa_r[2*k], pa_r[2*k+1]);
        xm_r[k]   <= cross_mag(px_r[2*k], px_r[2*k+1]);
        ext2_r[k] <= ext1_r[k];
      end
    end
  end

  // S3: scaled projection, own extent and projected partner extents
  logic [CMP_W-1:0]  lhs3_r [NUM_AXES];
  logic [CMP_W-1:0]  own_r  [NUM_AXES];
  logic [TERM_W-1:0] t0_r   [NUM_AXES];
  logic [TERM_W-1:0] t1_r   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        lhs3_r[k] <= CMP_W'(proj_r[k]) << AXIS_FRAC;
        own_r[k]  <= CMP_W'(ext2_r[k]) << (2 * AXIS_FRAC);
      end
      // first box axes against second box extents
      t0_r[0] <= TERM_W'(ext2_r[2]) * TERM_W'(xm_r[0]);
      t1_r[0] <= TERM_W'(ext2_r[3]) * TERM_W'(xm_r[1]);
      t0_r[1] <= TERM_W'(ext2_r[2]) * TERM_W'(xm_r[2]);
      t1_r[1] <= TERM_W'(ext2_r[3]) * TERM_W'(xm_r[3]);
      // second box axes against first box extents
      t0_r[2] <= TERM_W'(ext2_r[0]) * TERM_W'(xm_r[0]);
      t1_r[2] <= TERM_W'(ext2_r[1]) * TERM_W'(xm_r[2]);
      t0_r[3] <= TERM_W'(ext2_r[0]) * TERM_W'(xm_r[1]);
      t1_r[3] <= TERM_W'(ext2_r[1]) * TERM_W'(xm_r[3]);
    end
  end

  // S4: extent sums
  logic [CMP_W-1:0] lhs4_r [NUM_AXES];
  logic [CMP_W-1:0] rhs_r  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        lhs4_r[k] <= lhs3_r[k];
        rhs_r[k]  <= own_r[k] + CMP_W'(t0_r[k]) + CMP_W'(t1_r[k]);
      end
    end
  end

  // S5: compare, output register
  logic                overlap_r;
  logic [NUM_AXES-1:0] sep;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sep[k] = lhs4_r[k] > rhs_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      overlap_r <= ~|sep;
    end
  end

  assign out_bus.valid   = v5_r;
  assign out_bus.overlap = overlap_r;

endmodule

>>> rtl/core/oriented_rect_overlap_test_unit.sv
// Channel | Dir | Handshake       | Payload
// in_bus  | in  | valid / ready   | first_/second_ center, axes, extents
// out_bus | out | valid / ready   | overlap
//
// One item per cycle sustained while out_bus.ready stays high.
// An item passes through the input register, the two-entry queue and the five
// back-end stages (products, dot products, extent products, sums, compare).
// rst_n is synchronous, active low; it clears valids, queue pointers and count only.
// A stalled output fills the back end first, then the queue, then in_bus.ready drops.
module oriented_rect_overlap_test_unit
  import orot_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  orot_in_if.sink    in_bus,
  orot_out_if.source out_bus
);

  // front -> queue
  logic       push_valid;
  logic       push_ready;
  orot_item_t push_item;

  // queue -> back
  logic       pop_valid;
  logic       pop_ready;
  orot_item_t pop_item;

  // Front: registers the item, unpacks fields and forms centre differences.
  orot_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Short queue so front and back stall independently.
  orot_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: separating axis test over the four box axes, exact integer compare.
  orot_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_bus   (out_bus)
  );

endmodule

>>> tb/tb_oriented_rect_overlap_test_unit.sv
module tb_oriented_rect_overlap_test_unit
  import orot_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Q15.8 one, Q1.14 one and cos(45 deg) in Q1.14
  localparam int ONE        = 256;
  localparam int UNIT_AXIS  = 16384;
  localparam int DIAG_AXIS  = 11585;
  localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN  = -(1 << (COORD_W - 1));
  localparam int AXIS_MAX   = (1 << (AXIS_W - 1)) - 1;
  localparam int AXIS_MIN   = -(1 << (AXIS_W - 1));
  localparam int PHASE_ITEMS = 470;     // random items per pacing phase
  localparam int TAIL_CYCLES = 20;      // settle margin after the final drain

  // One input item: a pair of oriented rectangles, packed as on the bus
  typedef struct {
    logic [CENTER_W-1:0] first_center;
    logic [AXES_W-1:0]   first_axes;
    logic [EXT_W-1:0]    first_extents;
    logic [CENTER_W-1:0] second_center;
    logic [AXES_W-1:0]   second_axes;
    logic [EXT_W-1:0]    second_extents;
  } rect_pair_t;

  // Expected verdict for one accepted pair, tagged with its acceptance order
  typedef struct {
    int unsigned seq;
    logic        overlap;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  orot_in_if  in_if ();
  orot_out_if out_if ();

  oriented_rect_overlap_test_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always #5 clk = ~clk;

  rect_pair_t  pair_q[$];      // pairs waiting to be offered
  verdict_t    verdict_q[$];   // verdicts owed by the block, oldest first
  rect_pair_t  cur_pair;       // pair currently on in_bus
  int unsigned pairs_queued   = 0;
  int unsigned pairs_accepted = 0;
  int unsigned verdicts_seen  = 0;
  int unsigned overlap_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Packing helpers: signed values are simply truncated to the field width.
  // ---------------------------------------------------------------------------
  function automatic logic [CENTER_W-1:0] pack_centre(int x, int y);
    logic [31:0] xv, yv;
    xv = x;
    yv = y;
    return {yv[COORD_W-1:0], xv[COORD_W-1:0]};
  endfunction

  function automatic logic [AXES_W-1:0] pack_axes(int ax, int ay, int bx, int by);
    logic [31:0] v0, v1, v2, v3;
    v0 = ax;
    v1 = ay;
    v2 = bx;
    v3 = by;
    return {v3[AXIS_W-1:0], v2[AXIS_W-1:0], v1[AXIS_W-1:0], v0[AXIS_W-1:0]};
  endfunction

  function automatic logic [EXT_W-1:0] pack_ext(int e0, int e1);
    logic [31:0] v0, v1;
    v0 = e0;
    v1 = e1;
    return {v1[COORD_W-1:0], v0[COORD_W-1:0]};
  endfunction

  task automatic queue_pair(input logic [CENTER_W-1:0] c1, input logic [AXES_W-1:0] a1,
                            input logic [EXT_W-1:0] e1, input logic [CENTER_W-1:0] c2,
                            input logic [AXES_W-1:0] a2, input logic [EXT_W-1:0] e2);
    rect_pair_t p;
    p.first_center   = c1;
    p.first_axes     = a1;
    p.first_extents  = e1;
    p.second_center  = c2;
    p.second_axes    = a2;
    p.second_extents = e2;
    pair_q.push_back(p);
    pairs_queued++;
  endtask

  // ---------------------------------------------------------------------------
  // Separating axis predictor. All terms are exact in 64 bits: the shifted
  // projection stays below 2^56 and the extent sum below 2^57, so no clamp.
  // ---------------------------------------------------------------------------
  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // True when this axis splits the pair: centre gap beats the summed reach
  function automatic bit axis_splits(longint proj, longint own_ext, longint e0, longint k0,
                                     longint e1, longint k1);
    return (proj << AXIS_FRAC) > ((own_ext << (2 * AXIS_FRAC)) + e0 * k0 + e1 * k1);
  endfunction

  function automatic logic predict_overlap(rect_pair_t p);
    longint a[4];
    longint b[4];
    longint dx, dy, ea0, ea1, eb0, eb1, k00, k01, k10, k11;
    bit     split;
    for (int i = 0; i < NUM_AXES; i++) begin
      a[i] = longint'($signed(p.first_axes[i*AXIS_W +: AXIS_W]));
      b[i] = longint'($signed(p.second_axes[i*AXIS_W +: AXIS_W]));
    end
    dx  = longint'($signed(p.first_center[0 +: COORD_W]))
        - longint'($signed(p.second_center[0 +: COORD_W]));
    dy  = longint'($signed(p.first_center[COORD_W +: COORD_W]))
        - longint'($signed(p.second_center[COORD_W +: COORD_W]));
    ea0 = longint'(p.first_extents[0 +: COORD_W]);
    ea1 = longint'(p.first_extents[COORD_W +: COORD_W]);
    eb0 = longint'(p.second_extents[0 +: COORD_W]);
    eb1 = longint'(p.second_extents[COORD_W +: COORD_W]);
    // |axis . axis| couplings between the two boxes
    k00 = magnitude(a[0] * b[0] + a[1] * b[1]);
    k01 = magnitude(a[0] * b[2] + a[1] * b[3]);
    k10 = magnitude(a[2] * b[0] + a[3] * b[1]);
    k11 = magnitude(a[2] * b[2] + a[3] * b[3]);
    split = axis_splits(magnitude(a[0] * dx + a[1] * dy), ea0, eb0, k00, eb1, k01)
         || axis_splits(magnitude(a[2] * dx + a[3] * dy), ea1, eb0, k10, eb1, k11)
         || axis_splits(magnitude(b[0] * dx + b[1] * dy), eb0, ea0, k00, ea1, k10)
         || axis_splits(magnitude(b[2] * dx + b[3] * dy), eb1, ea0, k01, ea1, k11);
    return split ? 1'b0 : 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] noise64();
    return {$urandom, $urandom};
  endfunction

  // Rotated axis pair, mostly unit length, sometimes scaled by 0.5 .. 1.9
  function automatic logic [AXES_W-1:0] rotated_axes();
    real ang, scl;
    int  c, s;
    ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
    scl = ($urandom_range(99) < 80) ? 1.0 : 0.5 + $urandom_range(0, 140) / 100.0;
    c   = int'($cos(ang) * UNIT_AXIS * scl);
    s   = int'($sin(ang) * UNIT_AXIS * scl);
    return pack_axes(c, s, -s, c);
  endfunction

  function automatic int signed_range(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Two axis-aligned boxes exactly touching along x or y, or one LSB apart
  task automatic queue_touching_pair();
    int e1, e2, gap, cx, cy, sx, sy;
    logic along_x;
    e1      = $urandom_range(0, 1 << 20);
    e2      = $urandom_range(0, 1 << 20);
    gap     = e1 + e2 + int'($urandom_range(0, 1));
    gap     = $urandom_range(0, 1) ? gap : -gap;
    cx      = signed_range(1 << 20);
    cy      = signed_range(1 << 20);
    sx      = $urandom_range(0, 1) ? UNIT_AXIS : -UNIT_AXIS;
    sy      = $urandom_range(0, 1) ? UNIT_AXIS : -UNIT_AXIS;
    along_x = 1'($urandom_range(0, 1));
    if (along_x) begin
      queue_pair(pack_centre(cx, cy), pack_axes(sx, 0, 0, sy),
                 pack_ext(e1, $urandom_range(0, 1 << 20)),
                 pack_centre(cx + gap, cy), pack_axes(sy, 0, 0, sx),
                 pack_ext(e2, $urandom_range(0, 1 << 20)));
    end else begin
      queue_pair(pack_centre(cx, cy), pack_axes(sx, 0, 0, sy),
                 pack_ext($urandom_range(0, 1 << 20), e1),
                 pack_centre(cx, cy + gap), pack_axes(-sx, 0, 0, sy),
                 pack_ext($urandom_range(0, 1 << 20), e2));
    end
  endtask

  task automatic queue_random_pair();
    int cx, cy, pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // raw noise: every bit of every field toggles
      queue_pair(CENTER_W'(noise64()), noise64(), EXT_W'(noise64()),
                 CENTER_W'(noise64()), noise64(), EXT_W'(noise64()));
    end else if (pick < 32) begin
      queue_touching_pair();
    end else begin
      // realistic broad-phase pair, centres close enough that verdicts mix
      cx = signed_range(1 << 20);
      cy = signed_range(1 << 20);
      queue_pair(pack_centre(cx, cy), rotated_axes(),
                 pack_ext($urandom_range(0, 4096), $urandom_range(0, 4096)),
                 pack_centre(cx + signed_range(8000), cy + signed_range(8000)),
                 rotated_axes(),
                 pack_ext($urandom_range(0, 4096), $urandom_range(0, 4096)));
    end
  endtask

  task automatic queue_directed_pairs();
    logic [AXES_W-1:0] aligned, diag, max_neg;
    aligned = pack_axes(UNIT_AXIS, 0, 0, UNIT_AXIS);
    diag    = pack_axes(DIAG_AXIS, DIAG_AXIS, -DIAG_AXIS, DIAG_AXIS);
    max_neg = pack_axes(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN);
    // all-zero and all-one fields
    queue_pair('0, '0, '0, '0, '0, '0);
    queue_pair('1, '1, '1, '1, '1, '1);
    // coincident unit squares
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(0, 0), aligned, pack_ext(ONE, ONE));
    // touching counts as overlap; one LSB further apart is separated (x, then y)
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(2 * ONE, 0), aligned, pack_ext(ONE, ONE));
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(2 * ONE + 1, 0), aligned, pack_ext(ONE, ONE));
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(0, -2 * ONE), aligned, pack_ext(ONE, ONE));
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(0, -2 * ONE - 1), aligned, pack_ext(ONE, ONE));
    // diamond against square: only the second box's axis 0, then axis 1, splits, then none
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(2 * ONE, 2 * ONE), diag, pack_ext(ONE, ONE));
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(2 * ONE, -2 * ONE), diag, pack_ext(ONE, ONE));
    queue_pair(pack_centre(0, 0), aligned, pack_ext(ONE, ONE),
               pack_centre(ONE, ONE), diag, pack_ext(ONE, ONE));
    // opposite coordinate extremes, largest negative axes, full / zero extents
    queue_pair(pack_centre(COORD_MAX, COORD_MAX), max_neg, '1,
               pack_centre(COORD_MIN, COORD_MIN), max_neg, '1);
    queue_pair(pack_centre(COORD_MAX, COORD_MAX), max_neg, '0,
               pack_centre(COORD_MIN, COORD_MIN), max_neg, '0);
    queue_pair(pack_centre(COORD_MIN, COORD_MAX),
               pack_axes(AXIS_MAX, AXIS_MIN, AXIS_MIN, AXIS_MAX), '1,
               pack_centre(COORD_MAX, COORD_MIN),
               pack_axes(AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MIN), pack_ext(0, COORD_MAX));
    // degenerate zero axes: a pair with no axes can never be split, one aligned box can
    queue_pair(pack_centre(COORD_MAX, 0), '0, pack_ext(ONE, ONE),
               pack_centre(COORD_MIN, 0), '0, pack_ext(ONE, ONE));
    queue_pair(pack_centre(COORD_MAX, 0), '0, pack_ext(ONE, ONE),
               pack_centre(COORD_MIN, 0), aligned, pack_ext(ONE, ONE));
    // non-unit and non-orthogonal axes taken as given
    queue_pair(pack_centre(0, 0), pack_axes(AXIS_MAX, 0, 0, AXIS_MAX), pack_ext(ONE, ONE),
               pack_centre(2 * ONE, 0), aligned, pack_ext(ONE, ONE));
    queue_pair(pack_centre(0, 0), pack_axes(UNIT_AXIS, 0, DIAG_AXIS, DIAG_AXIS),
               pack_ext(ONE, ONE),
               pack_centre(3 * ONE, ONE), aligned, pack_ext(ONE, ONE));
    // one huge box against a point far off; point boxes coincident and adjacent
    queue_pair(pack_centre(0, 0), aligned, '1,
               pack_centre(COORD_MAX, COORD_MIN), aligned, '0);
    queue_pair(pack_centre(5, -7), aligned, '0, pack_centre(5, -7), diag, '0);
    queue_pair(pack_centre(5, -7), aligned, '0, pack_centre(6, -7), aligned, '0);
  endtask

  // Wait until every queued pair has come back as a verdict
  task automatic drain();
    while (verdicts_seen != pairs_queued) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: records the verdict of each accepted pair, then offers the next
  // one unless the pacing knob says idle. valid is updated only when free or taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic offer;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        verdict_q.push_back('{seq: pairs_accepted, overlap: predict_overlap(cur_pair)});
        pairs_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        offer = (pair_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          cur_pair                 = pair_q.pop_front();
          in_if.first_center      <= cur_pair.first_center;
          in_if.first_axes        <= cur_pair.first_axes;
          in_if.first_extents     <= cur_pair.first_extents;
          in_if.second_center     <= cur_pair.second_center;
          in_if.second_axes       <= cur_pair.second_axes;
          in_if.second_extents    <= cur_pair.second_extents;
        end
        in_if.valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each verdict is matched against the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0b with no pair outstanding", out_if.overlap));
        end else begin
          want = verdict_q.pop_front();
          if (out_if.overlap !== want.overlap)
            report_mismatch($sformatf("pair %0d: overlap %0b, expected %0b",
                                      want.seq, out_if.overlap, want.overlap));
        end
        verdicts_seen++;
        if (out_if.overlap === 1'b1) overlap_seen++;
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed pairs, then four pacing phases of random pairs.
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid          = 1'b0;
    in_if.first_center   = '0;
    in_if.first_axes     = '0;
    in_if.first_extents  = '0;
    in_if.second_center  = '0;
    in_if.second_axes    = '0;
    in_if.second_extents = '0;
    out_if.ready         = 1'b0;
    rst_n                = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed_pairs();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) queue_random_pair();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d rectangle pairs (%0d overlapping, %0d separated): directed corners,",
             verdicts_seen, overlap_seen, verdicts_seen - overlap_seen);
    $display("touching and one-LSB gaps, rotated boxes and raw noise under four pacing mixes.");
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: ends the run if verdicts stop arriving
  initial begin
    #2_000_000;
    $display("Timed out with %0d of %0d verdicts received", verdicts_seen, pairs_queued);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
